### rtl/core/pbcd_pkg.sv
package pbcd_pkg;

    // Display and value dimensions.
    localparam int MAX_TUBES  = 8;
    localparam int VALUE_BITS = 27;

    // Field widths of the channels.
    localparam int CFG_W  = 4;
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;

    // Decimal digits needed for a VALUE_BITS wide value (31/100 bounds log10(2) from above).
    localparam int BCD_DIGITS = (VALUE_BITS * 31) / 100 + 1;
    localparam int BCD_W      = NIB_W * BCD_DIGITS;
    localparam int WORD_W     = BCD_W + VALUE_BITS;

    // Shift-and-add-3 conversion, split into stages of a few steps each.
    localparam int STEPS_PER_STAGE = 7;
    localparam int DD_STAGES = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Frame geometry: a blank frame is the longest at MAX_TUBES/2+1 bytes.
    localparam int MAX_BYTES  = MAX_TUBES / 2 + 1;
    localparam int PAIR_TUBES = 2 * MAX_BYTES;
    localparam int PTR_W      = $clog2(MAX_BYTES);
    localparam int TUBE_W     = $clog2(MAX_TUBES + 1);

    localparam logic [NIB_W-1:0]  BLANK_CODE = NIB_W'(15);
    localparam logic [BYTE_W-1:0] CLEAR_BYTE = BYTE_W'(255);
    localparam logic [CFG_W-1:0]  TUBES_RESET = CFG_W'(8);

    // Command codes.
    localparam logic OP_SHOW  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BYTE_W-1:0] t_byte;

endpackage

### rtl/core/packed_bcd_display_frame.sv
// Packed BCD frame builder for a chain of decimal display tube drivers.
//
// Input channel (i_valid / o_stall) carries one transaction per command:
// i_opcode selects show (i_number in decimal) or clear. Output channel
// (o_valid / i_stall) carries the frame bytes, highest tubes first, with
// o_frame_last set on the byte that closes the frame (the latch point).
// A show frame has ceil(tubes/2) bytes, a clear frame tubes/2+1 bytes of 255.
// The tube count is written over the cfg channel (always ready); the user
// must write it only while idle, which the block itself does not enforce.
//
// An accepted command passes the input register, the DD_STAGES stages of the
// shift-and-add-3 conversion pipeline and the frame register, which drives
// the outputs. The frame register sends one frame byte per cycle while the
// output does not stall, and holds a command until all of its frame's bytes
// (1 to 5; 4 or 5 with eight tubes) are taken; the pipeline behind it can
// hold further commands meanwhile.
// Reset (synchronous, active low) empties the pipeline and sets the tube
// count to 8. A stall on the output holds the current byte and backs the
// pipeline up stage by stage until o_stall is raised to the sender.
module packed_bcd_display_frame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_opcode,
    input  logic [pbcd_pkg::VALUE_BITS-1:0] i_number,
    // Frame byte channel.
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pbcd_pkg::BYTE_W-1:0]   o_frame_byte,
    output logic                          o_frame_last,
    // Tube count register write channel.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pbcd_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int D = pbcd_pkg::DD_STAGES;

    // One slice of the binary to BCD conversion. The BCD digits sit above the
    // remaining binary bits; each step corrects digits of 5 or more by 3 and
    // shifts the whole word left by one bit.
    function automatic pbcd_pkg::t_word dd_slice(input pbcd_pkg::t_word w_in, input int stage);
        pbcd_pkg::t_word w;
        logic [pbcd_pkg::NIB_W-1:0] nib;
        w = w_in;
        for (int j = 0; j < pbcd_pkg::STEPS_PER_STAGE; j++) begin
            if (stage * pbcd_pkg::STEPS_PER_STAGE + j < pbcd_pkg::VALUE_BITS) begin
                for (int d = 0; d < pbcd_pkg::BCD_DIGITS; d++) begin
                    nib = w[pbcd_pkg::VALUE_BITS + pbcd_pkg::NIB_W*d +: pbcd_pkg::NIB_W];
                    if (nib >= pbcd_pkg::NIB_W'(5)) begin
                        nib = nib + pbcd_pkg::NIB_W'(3);
                    end
                    w[pbcd_pkg::VALUE_BITS + pbcd_pkg::NIB_W*d +: pbcd_pkg::NIB_W] = nib;
                end
                w = w << 1;
            end
        end
        return w;
    endfunction

    // Configuration.
    logic [pbcd_pkg::CFG_W-1:0]  r_tube_count;
    logic [pbcd_pkg::TUBE_W-1:0] w_tubes;

    // Conversion pipeline: stage 0 is the input register.
    logic                 r_valid [D+1];
    logic                 r_op    [D+1];
    pbcd_pkg::t_word      r_word  [D+1];
    logic                 w_ready [D+1];

    // Frame register.
    logic                 r_fvalid;
    logic [pbcd_pkg::PTR_W-1:0] r_ptr;
    pbcd_pkg::t_byte      r_fbyte [pbcd_pkg::MAX_BYTES];
    pbcd_pkg::t_byte      n_fbyte [pbcd_pkg::MAX_BYTES];
    logic [pbcd_pkg::PTR_W-1:0] n_ptr;
    logic                 w_fdone;
    logic                 w_ffree;
    logic                 w_in_accept;

    logic [pbcd_pkg::BCD_W-1:0] w_bcd;
    logic [pbcd_pkg::BCD_W + pbcd_pkg::NIB_W*pbcd_pkg::PAIR_TUBES-1:0] w_bcd_ext;
    logic [pbcd_pkg::NIB_W-1:0] w_nib [pbcd_pkg::PAIR_TUBES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tube_count <= pbcd_pkg::TUBES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tube_count <= i_cfg_data;
        end
    end

    // A count of zero acts as one tube, a count above the chain saturates.
    always_comb begin
        if (r_tube_count == '0) begin
            w_tubes = pbcd_pkg::TUBE_W'(1);
        end else if (int'(r_tube_count) > pbcd_pkg::MAX_TUBES) begin
            w_tubes = pbcd_pkg::TUBE_W'(pbcd_pkg::MAX_TUBES);
        end else begin
            w_tubes = pbcd_pkg::TUBE_W'(r_tube_count);
        end
    end

    // The frame register frees up when its last byte is taken.
    assign w_fdone = r_fvalid && !i_stall && (r_ptr == '0);
    assign w_ffree = !r_fvalid || w_fdone;

    // Backpressure runs from the frame register down to the input register.
    always_comb begin
        w_ready[D] = !r_valid[D] || w_ffree;
        for (int s = D - 1; s >= 0; s--) begin
            w_ready[s] = !r_valid[s] || w_ready[s+1];
        end
    end

    assign o_stall     = !w_ready[0];
    assign w_in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= D; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int s = 1; s <= D; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_op[0]   <= i_opcode;
            r_word[0] <= {{pbcd_pkg::BCD_W{1'b0}}, i_number};
        end
        for (int s = 1; s <= D; s++) begin
            if (w_ready[s]) begin
                r_op[s]   <= r_op[s-1];
                r_word[s] <= dd_slice(r_word[s-1], s - 1);
            end
        end
    end

    // Tube nibbles from the finished BCD word. A tube shows its digit when it
    // lies within the number's decimal length (tube 1 always does, so zero
    // shows as a single 0), and the blank code otherwise.
    assign w_bcd     = r_word[D][pbcd_pkg::WORD_W-1 -: pbcd_pkg::BCD_W];
    assign w_bcd_ext = {{(pbcd_pkg::NIB_W*pbcd_pkg::PAIR_TUBES){1'b0}}, w_bcd};

    always_comb begin
        for (int t = 0; t < pbcd_pkg::PAIR_TUBES; t++) begin
            if (t == 0 || ((w_bcd_ext >> (pbcd_pkg::NIB_W*t)) != '0)) begin
                w_nib[t] = w_bcd_ext[pbcd_pkg::NIB_W*t +: pbcd_pkg::NIB_W];
            end else begin
                w_nib[t] = pbcd_pkg::BLANK_CODE;
            end
        end
    end

    // Byte p pairs tube 2p+2 (high nibble) with tube 2p+1 (low nibble); a high
    // tube above the count leaves a zero nibble. Bytes go out from the top pair.
    always_comb begin
        for (int p = 0; p < pbcd_pkg::MAX_BYTES; p++) begin
            if (r_op[D] == pbcd_pkg::OP_CLEAR) begin
                n_fbyte[p] = pbcd_pkg::CLEAR_BYTE;
            end else if (2*p + 2 > int'(w_tubes)) begin
                n_fbyte[p] = {{pbcd_pkg::NIB_W{1'b0}}, w_nib[2*p]};
            end else begin
                n_fbyte[p] = {w_nib[2*p+1], w_nib[2*p]};
            end
        end
        if (r_op[D] == pbcd_pkg::OP_CLEAR) begin
            n_ptr = pbcd_pkg::PTR_W'(w_tubes >> 1);
        end else begin
            n_ptr = pbcd_pkg::PTR_W'((w_tubes - pbcd_pkg::TUBE_W'(1)) >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
            r_ptr    <= '0;
        end else if (w_ffree) begin
            r_fvalid <= r_valid[D];
            r_ptr    <= n_ptr;
        end else if (!i_stall) begin
            r_ptr <= r_ptr - pbcd_pkg::PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ffree) begin
            r_fbyte <= n_fbyte;
        end
    end

    assign o_valid      = r_fvalid;
    assign o_frame_byte = r_fbyte[r_ptr];
    assign o_frame_last = (r_ptr == '0);

    // A frame is delivered without gaps: a taken byte that is not the last
    // one is followed by another valid byte.
    a_frame_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_frame_last |=> o_valid)
        else $error("frame broken before its last byte");

    // A converted item waiting on a busy frame register keeps its value.
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[D] && !w_ffree |=> r_valid[D] && $stable(r_word[D]) && $stable(r_op[D]))
        else $error("pipeline tail lost an item while held");

    // An accepted command is captured by the input register.
    a_input_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_valid[0])
        else $error("accepted command not captured");

endmodule

### verif/tb_packed_bcd_display_frame.sv
`timescale 1ns / 1ps

module tb_packed_bcd_display_frame;

    // The slowest correct run is about 450 commands, each with up to five frame bytes,
    // random output stalls per byte, random sender gaps and the conversion latency,
    // plus one long receiver hold-off. The watchdog limit CYCLE_LIMIT lies above that.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = pbcd_pkg::DD_STAGES + 2 + pbcd_pkg::MAX_BYTES + 10;
    localparam int IDLE_PCT     = 9;

    typedef struct packed {
        pbcd_pkg::t_byte data;
        logic            last;
    } t_frame_entry;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_opcode;
    logic [pbcd_pkg::VALUE_BITS-1:0] i_number;
    logic                            o_valid;
    logic                            i_stall;
    logic [pbcd_pkg::BYTE_W-1:0]     o_frame_byte;
    logic                            o_frame_last;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [pbcd_pkg::CFG_W-1:0]      i_cfg_data;

    // Bytes the block still owes, oldest first, and the tube count it is using.
    t_frame_entry               frame_q[$];
    logic [pbcd_pkg::CFG_W-1:0] tube_cfg;

    // Traffic shaping. idle_en turns random gaps and stalls on both sides on or off;
    // rx_hold forces the receiver to stall for a long stretch.
    bit idle_en;
    bit rx_hold;

    int err_count;
    int cycles;
    int show_cmds;
    int clear_cmds;
    int bytes_checked;
    int cfg_writes;

    packed_bcd_display_frame uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog. A hung handshake or a lost byte ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes outstanding.",
                     cycles, frame_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every mismatch goes through here: one line each, and all of them are counted.
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Computes the frame that one command produces under the given tube count
    // register, and appends its bytes to the outstanding queue.
    function automatic void queue_frame(input logic op,
                                        input logic [pbcd_pkg::VALUE_BITS-1:0] num,
                                        input logic [pbcd_pkg::CFG_W-1:0] tubes_reg);
        int                         tubes;
        int                         nbytes;
        int                         len;
        int unsigned                rest;
        logic [pbcd_pkg::NIB_W-1:0] digits [pbcd_pkg::MAX_TUBES];
        logic [pbcd_pkg::NIB_W-1:0] d;
        pbcd_pkg::t_byte            acc;
        t_frame_entry               e;

        // A count of zero still drives one tube; anything above the chain length saturates.
        tubes = int'(tubes_reg);
        if (tubes < 1)
            tubes = 1;
        if (tubes > pbcd_pkg::MAX_TUBES)
            tubes = pbcd_pkg::MAX_TUBES;

        if (op == pbcd_pkg::OP_CLEAR) begin
            nbytes = tubes / 2 + 1;
            for (int b = 0; b < nbytes; b++) begin
                e.data = pbcd_pkg::CLEAR_BYTE;
                e.last = (b == nbytes - 1);
                frame_q.push_back(e);
            end
            return;
        end

        // Decimal digits, least significant first. Digits beyond the last tube drop off.
        rest = 32'(num);
        for (int t = 0; t < pbcd_pkg::MAX_TUBES; t++) begin
            digits[t] = pbcd_pkg::NIB_W'(rest % 10);
            rest      = rest / 10;
        end

        // Zero still has one digit, so tube 1 shows 0 rather than a blank.
        len  = 0;
        rest = 32'(num);
        do begin
            len++;
            rest = rest / 10;
        end while (rest != 0);

        // Walk from the top tube down. Even tubes go in the high nibble and odd tubes
        // close the byte, so an odd tube count opens with a zero high nibble.
        acc = '0;
        for (int t = tubes; t > 0; t--) begin
            d = (t <= len) ? digits[t-1] : pbcd_pkg::BLANK_CODE;
            if (t % 2 == 1) begin
                acc[pbcd_pkg::NIB_W-1:0] = d;
                e.data = acc;
                e.last = (t == 1);
                frame_q.push_back(e);
                acc = '0;
            end else begin
                acc = {d, {pbcd_pkg::NIB_W{1'b0}}};
            end
        end
    endfunction

    // Output side: check each accepted byte against the oldest outstanding one, then
    // pick the stall for the next cycle. i_stall is read before its update here, so
    // the check sees exactly the value the block saw at this edge.
    always @(posedge i_clk) begin
        t_frame_entry want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_q.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                          o_frame_byte, o_frame_last));
            end else begin
                want = frame_q.pop_front();
                bytes_checked++;
                if (o_frame_byte !== want.data)
                    report_mismatch($sformatf("frame byte %02h, expected %02h",
                                              o_frame_byte, want.data));
                if (o_frame_last !== want.last)
                    report_mismatch($sformatf("frame last %0b, expected %0b on byte %02h",
                                              o_frame_last, want.last, want.data));
            end
        end
        i_stall <= rx_hold || (idle_en && ($urandom_range(0, 99) < IDLE_PCT));
    end

    // Offers one command and returns at the edge where it is accepted, with i_valid
    // still high so that a following command can go out back to back.
    task automatic send_command(input logic op, input logic [pbcd_pkg::VALUE_BITS-1:0] num);
        while (idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_number <= num;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        queue_frame(op, num, tube_cfg);
        if (op == pbcd_pkg::OP_CLEAR)
            clear_cmds++;
        else
            show_cmds++;
    endtask

    // The tube count only changes while nothing is in flight: stop sending, let the
    // last frame drain completely, then write the register.
    task automatic write_tube_count(input logic [pbcd_pkg::CFG_W-1:0] value);
        i_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        tube_cfg = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly numbers whose length falls near the tube count, so that the boundary
    // between shown digits and blanks moves around; some full-width values too.
    function automatic logic [pbcd_pkg::VALUE_BITS-1:0] random_number();
        int unsigned span;
        int          k;
        case ($urandom_range(0, 3))
            0: return pbcd_pkg::VALUE_BITS'($urandom);
            1: return pbcd_pkg::VALUE_BITS'($urandom_range(0, 9));
            2: begin
                k    = $urandom_range(1, 8);
                span = 1;
                for (int i = 0; i < k; i++)
                    span = span * 10;
                return pbcd_pkg::VALUE_BITS'($urandom_range(0, span - 1));
            end
            default: return pbcd_pkg::VALUE_BITS'($urandom_range(0, 999));
        endcase
    endfunction

    function automatic logic random_opcode();
        return ($urandom_range(0, 3) == 0) ? pbcd_pkg::OP_CLEAR : pbcd_pkg::OP_SHOW;
    endfunction

    // After reset the block must drive a full chain of eight tubes.
    task automatic test_reset_tube_count();
        send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(0));
        send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(12345678));
        send_command(pbcd_pkg::OP_CLEAR, pbcd_pkg::VALUE_BITS'(0));
    endtask

    // Extremes of the number at eight tubes, including a value with more digits
    // than there are tubes and a clear that carries a nonzero number.
    task automatic test_number_extremes();
        send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(1));
        send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(10));
        send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(99999999));
        send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(100000000));
        send_command(pbcd_pkg::OP_SHOW, {pbcd_pkg::VALUE_BITS{1'b1}});
        send_command(pbcd_pkg::OP_CLEAR, {pbcd_pkg::VALUE_BITS{1'b1}});
    endtask

    // Frame shapes across the tube count: odd and even counts, zero, and counts
    // above the chain length, which must behave as eight.
    task automatic test_tube_count_range();
        logic [pbcd_pkg::CFG_W-1:0] counts [7];
        counts = '{4'd1, 4'd2, 4'd7, 4'd0, 4'd9, 4'd15, 4'd8};
        foreach (counts[i]) begin
            write_tube_count(counts[i]);
            send_command(pbcd_pkg::OP_SHOW, pbcd_pkg::VALUE_BITS'(4321));
            send_command(pbcd_pkg::OP_CLEAR, pbcd_pkg::VALUE_BITS'(0));
        end
    endtask

    // A stretch with no gaps or stalls on either side, so transactions go back to back.
    task automatic test_no_idle_stretch(input int n);
        idle_en = 1'b0;
        for (int i = 0; i < n; i++)
            send_command(random_opcode(), random_number());
        idle_en = 1'b1;
    endtask

    // The receiver stalls for a long time while the sender keeps offering commands,
    // so the pipeline fills up and o_stall has to reach the sender.
    task automatic test_output_backpressure(input int n);
        idle_en = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < n; i++)
            send_command(random_opcode(), random_number());
        idle_en = 1'b1;
    endtask

    // Random commands in phases, with a new tube count between phases. Most counts
    // are legal, a few are zero or above the chain length.
    task automatic test_random_traffic(input int n);
        logic [pbcd_pkg::CFG_W-1:0] tc;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                if ($urandom_range(0, 4) == 0)
                    tc = pbcd_pkg::CFG_W'($urandom_range(0, 15));
                else
                    tc = pbcd_pkg::CFG_W'($urandom_range(1, pbcd_pkg::MAX_TUBES));
                write_tube_count(tc);
            end
            send_command(random_opcode(), random_number());
        end
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_opcode    = pbcd_pkg::OP_SHOW;
        i_number    = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        idle_en     = 1'b1;
        rx_hold     = 1'b0;
        tube_cfg    = pbcd_pkg::TUBES_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_tube_count();
        test_number_extremes();
        test_tube_count_range();
        test_random_traffic(280);
        write_tube_count(pbcd_pkg::CFG_W'(pbcd_pkg::MAX_TUBES));
        test_output_backpressure(40);
        test_no_idle_stretch(60);
        write_tube_count(pbcd_pkg::CFG_W'(1));
        test_random_traffic(20);

        // Let the last frame drain, then give the block time to show any stray byte.
        i_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d show and %0d clear commands over %0d tube count writes;",
                 show_cmds, clear_cmds, cfg_writes);
        $display("checked %0d frame bytes, with a long output hold-off and a gap-free run.",
                 bytes_checked);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches.", err_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
